// File: sv/dcon_pkg.sv
`timescale 1ns / 1ps

package dcon_pkg;

   // result kinds
   localparam logic [1:0] KIND_CHAR   = 2'd0;
   localparam logic [1:0] KIND_OUTPUT = 2'd1;
   localparam logic [1:0] KIND_UART   = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_FIRST_ADDRESS  = 2'd0;
   localparam logic [1:0] CSR_SECOND_ADDRESS = 2'd1;
   localparam logic [1:0] CSR_PARITY_ODD     = 2'd2;
   localparam logic [1:0] CSR_SPEED_INDEX    = 2'd3;

   typedef struct packed {
      logic take;
      logic decode;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic is_cr;
      logic len_zero;
      logic seq_empty;
      logic last_slot;
   } status_type;

endpackage

// File: sv/dcon_ctrl.sv
`timescale 1ns / 1ps

module dcon_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  dcon_pkg::status_type status,
   output dcon_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DECODE = 3'b010,
      ST_EMIT   = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      out_free     = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               if (status.is_cr && !status.len_zero) state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.seq_empty) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               if (status.last_slot) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: sv/dcon_datapath.sv
`timescale 1ns / 1ps

module dcon_datapath #(
   parameter int LINE_KEEP = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dcon_pkg::cmd_type    cmd,
   output dcon_pkg::status_type status,
   input  logic [7:0]           req_rx_byte,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_write_data,
   output logic [1:0]           rsp_result_kind,
   output logic [7:0]           rsp_tx_byte,
   output logic [1:0]           rsp_out_device,
   output logic [15:0]          rsp_out_value,
   output logic [11:0]          rsp_baud_divisor,
   output logic                 rsp_parity_odd,
   output logic                 rsp_last
);

   localparam int LEN_W = $clog2(LINE_KEEP + 2);
   localparam int IDX_W = $clog2(LINE_KEEP);
   localparam int NPOS  = 8;
   localparam int NSLOT = 9;

   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_AT      = 8'h40;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_QUERY   = 8'h3F;
   localparam logic [7:0] CH_GT      = 8'h3E;
   localparam logic [7:0] CH_M       = 8'h4D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_ONE     = 8'h31;
   localparam logic [7:0] CH_THREE   = 8'h33;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;

   localparam logic [15:0] RESET_FIRST_ADDRESS  = 16'h3030;
   localparam logic [15:0] RESET_SECOND_ADDRESS = 16'h3031;
   localparam logic [2:0]  RESET_SPEED_INDEX    = 3'd4;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
   } slot_type;

   function automatic logic [11:0] divisor(input logic [2:0] sp);
      logic [11:0] d;
      unique case (sp)
         3'd0: d = 12'h340;
         3'd1: d = 12'h1A0;
         3'd2: d = 12'h0CF;
         3'd3: d = 12'h067;
         3'd4: d = 12'h033;
         3'd5: d = 12'h019;
         3'd6: d = 12'h010;
         3'd7: d = 12'h008;
         default: d = 12'h008;
      endcase
      return d;
   endfunction

   function automatic logic [7:0] model_char(input logic [3:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd0: c = 8'h37;
         4'd1: c = 8'h30;
         4'd2: c = 8'h34;
         4'd3: c = 8'h33;
         4'd4: c = 8'h44;
         4'd5: c = CH_CR;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || ((c >= CH_UPPER_A) && (c <= 8'h46));
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return is_digit(c) || ((c >= CH_UPPER_A) && (c <= 8'h5A))
             || ((c >= 8'h61) && (c <= 8'h7A));
   endfunction

   function automatic logic [3:0] nibble(input logic [7:0] c);
      logic [7:0] t;
      t = (c <= CH_NINE) ? (c - CH_ZERO) : (c - 8'h37);
      return t[3:0];
   endfunction

   // early success on a terminator in the line or a zero address character
   function automatic logic addr_match(input logic [7:0] c1, input logic [7:0] c2,
                                       input logic [15:0] addr);
      logic r;
      if (c1 == 8'h00 || addr[15:8] == 8'h00) r = 1'b1;
      else if (c1 != addr[15:8])              r = 1'b0;
      else if (c2 == 8'h00 || addr[7:0] == 8'h00) r = 1'b1;
      else                                     r = (c2 == addr[7:0]);
      return r;
   endfunction

   logic [7:0]       line_chars_ff [LINE_KEEP];
   logic [LEN_W-1:0] line_length_ff, line_length_in;
   logic [7:0]       pos_ff [NPOS];
   logic [7:0]       pos_in [NPOS];
   slot_type         seq_ff [NSLOT];
   slot_type         seq_in [NSLOT];
   logic [3:0]       count_ff, count_in;
   logic [3:0]       slot_ff;
   logic [15:0]      first_address_ff, first_address_in;
   logic [15:0]      second_address_ff, second_address_in;
   logic             odd_parity_on_ff, odd_parity_on_in;
   logic [2:0]       speed_index_ff, speed_index_in;
   logic [1:0]       hex_dev_ff, hex_dev_in;
   logic [15:0]      hex_val_ff, hex_val_in;

   logic             is_cr;
   logic             match1, match2;
   logic [15:0]      sel_addr;
   logic [1:0]       alen;
   logic             hex_ok, pct_ok, pct_speed_ok;
   logic [2:0]       pct_speed;
   logic [2:0]       echo_len;
   logic             echo_stop;
   logic [3:0]       jj;
   slot_type         cur;

   assign is_cr = (req_rx_byte == CH_CR);

   // line position view: stored char below the count, CR at the count, else zero
   always_comb begin
      for (int i = 0; i < NPOS; i++) begin
         if (line_length_ff > LEN_W'(i))       pos_in[i] = line_chars_ff[IDX_W'(i)];
         else if (line_length_ff == LEN_W'(i)) pos_in[i] = CH_CR;
         else                                  pos_in[i] = 8'h00;
      end
   end

   always_comb begin
      line_length_in = line_length_ff;
      if (cmd.take) begin
         if (is_cr) line_length_in = '0;
         else if (line_length_ff < LEN_W'(LINE_KEEP + 1)) line_length_in = line_length_ff + 1'b1;
      end
   end

   // decode of the captured line into a reply buffer
   always_comb begin
      match1   = addr_match(pos_ff[1], pos_ff[2], first_address_ff);
      match2   = addr_match(pos_ff[1], pos_ff[2], second_address_ff);
      sel_addr = match1 ? first_address_ff : second_address_ff;
      if (sel_addr[15:8] == 8'h00)     alen = 2'd0;
      else if (sel_addr[7:0] == 8'h00) alen = 2'd1;
      else                             alen = 2'd2;

      hex_ok = (pos_ff[7] == CH_CR) && is_hex(pos_ff[3]) && is_hex(pos_ff[4])
               && is_hex(pos_ff[5]) && is_hex(pos_ff[6]);

      if (pos_ff[6] >= CH_THREE && pos_ff[6] <= CH_NINE) begin
         pct_speed    = 3'(pos_ff[6] - CH_THREE);
         pct_speed_ok = 1'b1;
      end else if (pos_ff[6] == CH_UPPER_A) begin
         pct_speed    = 3'd7;
         pct_speed_ok = 1'b1;
      end else begin
         pct_speed    = 3'd0;
         pct_speed_ok = 1'b0;
      end
      pct_ok = (pos_ff[7] == CH_CR) && is_alnum(pos_ff[1]) && is_alnum(pos_ff[2])
               && is_alnum(pos_ff[3]) && is_alnum(pos_ff[4])
               && !(pos_ff[1] == pos_ff[3] && pos_ff[2] == pos_ff[4])
               && (pos_ff[5] == CH_ZERO || pos_ff[5] == CH_ONE) && pct_speed_ok;

      echo_len  = 3'd0;
      echo_stop = 1'b0;
      for (int i = 1; i < 7; i++) begin
         if (!echo_stop && pos_ff[i] != 8'h00) echo_len = echo_len + 3'd1;
         else echo_stop = 1'b1;
      end

      for (int j = 0; j < NSLOT; j++) seq_in[j] = '{kind: dcon_pkg::KIND_CHAR, data: 8'h00};
      count_in   = 4'd0;
      hex_dev_in = match1 ? 2'd1 : 2'd2;
      hex_val_in = {nibble(pos_ff[3]), nibble(pos_ff[4]), nibble(pos_ff[5]),
                    nibble(pos_ff[6])};
      jj         = 4'd0;

      if ((pos_ff[0] == CH_DOLLAR || pos_ff[0] == CH_AT) && (match1 || match2)) begin
         if (pos_ff[0] == CH_DOLLAR) begin
            if (pos_ff[3] == CH_M) begin
               for (int j = 0; j < NSLOT; j++) begin
                  jj = 4'(j);
                  if (j == 0)                   seq_in[j].data = CH_BANG;
                  else if (jj <= {2'b00, alen}) seq_in[j].data = (j == 1) ? sel_addr[15:8]
                                                                          : sel_addr[7:0];
                  else seq_in[j].data = model_char(jj - 4'd1 - {2'b00, alen});
               end
               count_in = 4'd7 + {2'b00, alen};
            end
         end else if (pos_ff[3] != CH_CR && hex_ok) begin
            seq_in[0].kind = dcon_pkg::KIND_OUTPUT;
            seq_in[1].data = CH_GT;
            seq_in[2].data = CH_CR;
            count_in       = 4'd3;
         end else begin
            for (int j = 0; j < NSLOT; j++) begin
               jj = 4'(j);
               if (j == 0)                   seq_in[j].data = CH_QUERY;
               else if (jj <= {2'b00, alen}) seq_in[j].data = (j == 1) ? sel_addr[15:8]
                                                                       : sel_addr[7:0];
               else                          seq_in[j].data = CH_CR;
            end
            count_in = 4'd2 + {2'b00, alen};
         end
      end else if (pos_ff[0] == CH_PERCENT) begin
         if (pct_ok) begin
            seq_in[0].data = CH_BANG;
            for (int j = 1; j < NPOS; j++) seq_in[j].data = pos_ff[j];
            seq_in[8].kind = dcon_pkg::KIND_UART;
            count_in       = 4'd9;
         end else begin
            seq_in[0].data = CH_QUERY;
            for (int j = 1; j < NPOS; j++) begin
               if (3'(j) <= echo_len && j < 7) seq_in[j].data = pos_ff[j];
               else                             seq_in[j].data = CH_CR;
            end
            count_in = (echo_len == 3'd6) ? 4'd8 : ({1'b0, echo_len} + 4'd1);
         end
      end
   end

   // live settings: configuration writes, or a good % command
   always_comb begin
      first_address_in  = first_address_ff;
      second_address_in = second_address_ff;
      odd_parity_on_in  = odd_parity_on_ff;
      speed_index_in    = speed_index_ff;
      if (csr_write_enable) begin
         if (csr_index == dcon_pkg::CSR_FIRST_ADDRESS)  first_address_in  = csr_write_data;
         if (csr_index == dcon_pkg::CSR_SECOND_ADDRESS) second_address_in = csr_write_data;
         if (csr_index == dcon_pkg::CSR_PARITY_ODD)     odd_parity_on_in  = csr_write_data[0];
         if (csr_index == dcon_pkg::CSR_SPEED_INDEX)    speed_index_in    = csr_write_data[2:0];
      end else if (cmd.decode && pos_ff[0] == CH_PERCENT && pct_ok) begin
         first_address_in  = {pos_ff[1], pos_ff[2]};
         second_address_in = {pos_ff[3], pos_ff[4]};
         odd_parity_on_in  = pos_ff[5][0];
         speed_index_in    = pct_speed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff    <= '0;
         count_ff          <= 4'd0;
         slot_ff           <= 4'd0;
         first_address_ff  <= RESET_FIRST_ADDRESS;
         second_address_ff <= RESET_SECOND_ADDRESS;
         odd_parity_on_ff  <= 1'b0;
         speed_index_ff    <= RESET_SPEED_INDEX;
      end else begin
         line_length_ff    <= line_length_in;
         first_address_ff  <= first_address_in;
         second_address_ff <= second_address_in;
         odd_parity_on_ff  <= odd_parity_on_in;
         speed_index_ff    <= speed_index_in;
         if (cmd.decode) begin
            count_ff <= count_in;
            slot_ff  <= 4'd0;
         end else if (cmd.emit) begin
            slot_ff <= slot_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && !is_cr && line_length_ff < LEN_W'(LINE_KEEP)) begin
         line_chars_ff[line_length_ff[IDX_W-1:0]] <= req_rx_byte;
      end
      if (cmd.take && is_cr) begin
         for (int i = 0; i < NPOS; i++) pos_ff[i] <= pos_in[i];
      end
      if (cmd.decode) begin
         for (int j = 0; j < NSLOT; j++) seq_ff[j] <= seq_in[j];
         hex_dev_ff <= hex_dev_in;
         hex_val_ff <= hex_val_in;
      end
   end

   // output register
   assign cur = seq_ff[slot_ff];

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_result_kind  <= cur.kind;
         rsp_tx_byte      <= (cur.kind == dcon_pkg::KIND_CHAR) ? cur.data : 8'h00;
         rsp_out_device   <= (cur.kind == dcon_pkg::KIND_OUTPUT) ? hex_dev_ff : 2'd0;
         rsp_out_value    <= (cur.kind == dcon_pkg::KIND_OUTPUT) ? hex_val_ff : 16'h0000;
         rsp_baud_divisor <= (cur.kind == dcon_pkg::KIND_UART) ? divisor(speed_index_ff)
                                                                : 12'h000;
         rsp_parity_odd   <= (cur.kind == dcon_pkg::KIND_UART) ? odd_parity_on_ff : 1'b0;
         rsp_last         <= status.last_slot;
      end
   end

   assign status.is_cr     = is_cr;
   assign status.len_zero  = (line_length_ff == '0);
   assign status.seq_empty = (count_ff == 4'd0);
   assign status.last_slot = (slot_ff == count_ff - 4'd1);

endmodule

// File: sv/dcon_command_line_responder.sv
`timescale 1ns / 1ps

// Line-based ASCII command responder for two emulated digital I/O modules.
// Every received byte other than CR is taken and, while the buffer has room,
// stored in the line buffer. A CR after a non-empty line is transferred, the
// line is decoded into a reply buffer, and then one result per cycle (up to
// nine, or none) is emitted while the result side keeps taking them; no new
// byte is taken until the last result of the line is in the output register.
// That register holds one result, so the next byte is taken while it waits.
// The configuration port loads the two module addresses, parity and speed
// directly into the live settings; a good % command overwrites them.

module dcon_command_line_responder #(
   parameter int LINE_KEEP = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic [1:0]  rsp_out_device,
   output logic [15:0] rsp_out_value,
   output logic [11:0] rsp_baud_divisor,
   output logic        rsp_parity_odd,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   dcon_pkg::cmd_type    cmd;
   dcon_pkg::status_type status;

   dcon_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dcon_datapath #(
      .LINE_KEEP (LINE_KEEP)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_rx_byte      (req_rx_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_out_device   (rsp_out_device),
      .rsp_out_value    (rsp_out_value),
      .rsp_baud_divisor (rsp_baud_divisor),
      .rsp_parity_odd   (rsp_parity_odd),
      .rsp_last         (rsp_last)
   );

endmodule
